FILE: rtl/tmpq_pkg.sv
`default_nettype none
package tmpq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int HANDLE_BITS = 16;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W = (OCC_W > 8) ? OCC_W + 1 : 9;

  localparam int TIME_W   = 64;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 8;
  localparam int CODE_W   = 2;
  localparam int REQ_W    = 2;
  localparam int IDX_W    = 2;
  localparam int CFG_W    = 32;

  localparam int IN_DATA_W  = TIME_W + HANDLE_W + STATUS_W;
  localparam int OUT_DATA_W = HANDLE_W + TIME_W;

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  localparam logic [CODE_W-1:0] RES_VALID   = 2'd0;
  localparam logic [CODE_W-1:0] RES_EMPTY   = 2'd1;
  localparam logic [CODE_W-1:0] RES_STALE   = 2'd2;
  localparam logic [CODE_W-1:0] RES_INVALID = 2'd3;

  localparam logic [IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
  localparam logic [IDX_W-1:0] CFG_TOLERANCE   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_MAX_AGE     = 2'd2;

  localparam logic [7:0]       RST_MAX_ENTRIES = 8'd100;
  localparam logic [CFG_W-1:0] RST_TOLERANCE   = 32'd10000;
  localparam logic [CFG_W-1:0] RST_MAX_AGE     = 32'd500000;

  typedef struct packed {
    logic [REQ_W-1:0]       kind;
    logic [TIME_W-1:0]      item_time;
    logic [HANDLE_BITS-1:0] handle;
    logic [STATUS_W-1:0]    status;
  } cmd_t;

  function automatic logic [HANDLE_BITS-1:0] handle_in(input logic [HANDLE_W-1:0] h);
    logic [HANDLE_W+HANDLE_BITS-1:0] ext;
    ext = {{HANDLE_BITS{1'b0}}, h};
    return ext[HANDLE_BITS-1:0];
  endfunction

  function automatic logic [HANDLE_W-1:0] handle_out(input logic [HANDLE_BITS-1:0] h);
    logic [HANDLE_W+HANDLE_BITS-1:0] ext;
    ext = {{HANDLE_W{1'b0}}, h};
    return ext[HANDLE_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tmpq_front.sv
`default_nettype none
module tmpq_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [tmpq_pkg::REQ_W-1:0]         in_tuser,
  input  wire logic [tmpq_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                    cmd_valid,
  input  wire logic                               cmd_ready,
  output tmpq_pkg::cmd_t                          cmd
);

  // two-entry command queue
  tmpq_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           in_acc, keep, enq, deq;
  tmpq_pkg::cmd_t in_cmd;

  assign in_tready = (cnt_r != 2'd2);
  assign in_acc    = in_tvalid && in_tready;
  assign keep      = (in_tuser != tmpq_pkg::REQ_NONE);
  assign enq       = in_acc && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign deq       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    in_cmd.kind      = in_tuser;
    in_cmd.item_time = in_tdata[tmpq_pkg::TIME_W-1:0];
    in_cmd.handle    = tmpq_pkg::handle_in(
      in_tdata[tmpq_pkg::TIME_W +: tmpq_pkg::HANDLE_W]);
    in_cmd.status    = in_tdata[tmpq_pkg::TIME_W + tmpq_pkg::HANDLE_W +: tmpq_pkg::STATUS_W];
  end

  always_comb begin
    wr_ptr_nxt = enq ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = deq ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!enq && deq) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tmpq_back.sv
`default_nettype none
module tmpq_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cmd_valid,
  output logic                                    cmd_ready,
  input  wire tmpq_pkg::cmd_t                     cmd,
  input  wire logic                               cfg_valid,
  input  wire logic [tmpq_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [tmpq_pkg::CFG_W-1:0]         cfg_data,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [tmpq_pkg::CODE_W-1:0]             out_tuser,
  output logic [tmpq_pkg::OUT_DATA_W-1:0]         out_tdata
);

  localparam int REC_W = tmpq_pkg::TIME_W + tmpq_pkg::STATUS_W + tmpq_pkg::HANDLE_BITS;
  localparam int PTR_W = tmpq_pkg::PTR_W;
  localparam int OCC_W = tmpq_pkg::OCC_W;
  localparam int LIM_W = tmpq_pkg::LIM_W;
  localparam logic [PTR_W:0] DEPTH_P = (PTR_W + 1)'(tmpq_pkg::QUEUE_DEPTH);
  localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(tmpq_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(tmpq_pkg::QUEUE_DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  logic [REC_W-1:0] mem [tmpq_pkg::QUEUE_DEPTH];
  logic [REC_W-1:0] rd_q;

  logic [1:0]       state_r, state_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             clr_r, clr_nxt;
  logic [tmpq_pkg::TIME_W-1:0] qtime_r, qtime_nxt;

  logic [7:0]                 max_ent_r;
  logic [tmpq_pkg::CFG_W-1:0] tol_r;
  logic [tmpq_pkg::CFG_W-1:0] age_r;

  logic                                  outv_r, outv_nxt;
  logic [tmpq_pkg::CODE_W-1:0]           code_r, code_nxt;
  logic [tmpq_pkg::HANDLE_W-1:0]         oh_r, oh_nxt;
  logic [tmpq_pkg::TIME_W-1:0]           ot_r, ot_nxt;

  logic                 take, out_free, wr_en;
  logic [PTR_W-1:0]     tail, head_inc;
  logic [PTR_W:0]       tail_sum;
  logic [LIM_W-1:0]     limit, occ_plus;
  logic [tmpq_pkg::TIME_W-1:0]      rec_time, tol_sum, age_sum;
  logic [tmpq_pkg::STATUS_W-1:0]    rec_status;
  logic [tmpq_pkg::HANDLE_BITS-1:0] rec_handle;
  logic                 skip, stale, st_ok;

  assign cmd_ready = (state_r == ST_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign out_free  = !outv_r || out_tready;

  assign head_inc = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_sum = {1'b0, head_r} + (PTR_W + 1)'(occ_r);
  assign tail     = (tail_sum >= DEPTH_P) ? PTR_W'(tail_sum - DEPTH_P) : tail_sum[PTR_W-1:0];
  assign limit    = (LIM_W'(max_ent_r) > DEPTH_L) ? DEPTH_L : LIM_W'(max_ent_r);
  assign occ_plus = LIM_W'(occ_r) + 1'b1;

  assign rec_time   = rd_q[REC_W-1 -: tmpq_pkg::TIME_W];
  assign rec_status = rd_q[tmpq_pkg::HANDLE_BITS +: tmpq_pkg::STATUS_W];
  assign rec_handle = rd_q[tmpq_pkg::HANDLE_BITS-1:0];
  assign tol_sum    = rec_time + {32'd0, tol_r};
  assign age_sum    = rec_time + {32'd0, age_r};
  assign skip       = (occ_r > OCC_W'(1)) && (tol_sum < qtime_r);
  assign stale      = (age_sum < qtime_r);
  assign st_ok      = !rec_status[tmpq_pkg::STATUS_W-1] && (rec_status != '0);

  assign wr_en = take && (cmd.kind == tmpq_pkg::REQ_PUSH);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    occ_nxt   = occ_r;
    clr_nxt   = clr_r;
    qtime_nxt = qtime_r;
    outv_nxt  = outv_r && !out_tready;
    code_nxt  = code_r;
    oh_nxt    = oh_r;
    ot_nxt    = ot_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          case (cmd.kind)
            tmpq_pkg::REQ_PUSH: begin
              if (LIM_W'(occ_r) >= DEPTH_L) begin
                head_nxt = head_inc;
              end else if (occ_plus > limit) begin
                head_nxt = head_inc;
              end else begin
                occ_nxt = occ_r + 1'b1;
              end
            end
            tmpq_pkg::REQ_QUERY: begin
              qtime_nxt = cmd.item_time;
              clr_nxt   = 1'b0;
              if (clr_r || occ_r == '0) begin
                occ_nxt   = '0;
                state_nxt = ST_EMPTY;
              end else begin
                state_nxt = ST_READ;
              end
            end
            tmpq_pkg::REQ_RESET: begin
              clr_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (skip) begin
          head_nxt  = head_inc;
          occ_nxt   = occ_r - 1'b1;
          state_nxt = ST_READ;
        end else if (out_free) begin
          head_nxt  = head_inc;
          occ_nxt   = occ_r - 1'b1;
          outv_nxt  = 1'b1;
          state_nxt = ST_IDLE;
          if (stale) begin
            code_nxt = tmpq_pkg::RES_STALE;
            oh_nxt   = '0;
            ot_nxt   = '0;
          end else begin
            code_nxt = st_ok ? tmpq_pkg::RES_VALID : tmpq_pkg::RES_INVALID;
            oh_nxt   = tmpq_pkg::handle_out(rec_handle);
            ot_nxt   = rec_time;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          outv_nxt  = 1'b1;
          code_nxt  = tmpq_pkg::RES_EMPTY;
          oh_nxt    = '0;
          ot_nxt    = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      occ_r     <= '0;
      clr_r     <= 1'b0;
      outv_r    <= 1'b0;
      max_ent_r <= tmpq_pkg::RST_MAX_ENTRIES;
      tol_r     <= tmpq_pkg::RST_TOLERANCE;
      age_r     <= tmpq_pkg::RST_MAX_AGE;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      clr_r   <= clr_nxt;
      outv_r  <= outv_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          tmpq_pkg::CFG_MAX_ENTRIES: max_ent_r <= cfg_data[7:0];
          tmpq_pkg::CFG_TOLERANCE:   tol_r     <= cfg_data;
          tmpq_pkg::CFG_MAX_AGE:     age_r     <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    qtime_r <= qtime_nxt;
    code_r  <= code_nxt;
    oh_r    <= oh_nxt;
    ot_r    <= ot_nxt;
  end

  // record store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= {cmd.item_time, cmd.status, cmd.handle};
    end
    rd_q <= mem[head_r];
  end

  assign out_tvalid = outv_r;
  assign out_tuser  = code_r;
  assign out_tdata  = {ot_r, oh_r};

endmodule
`default_nettype wire

FILE: rtl/timestamp_matched_pose_queue.sv
`default_nettype none
// Pose record queue matched against sensor timestamps. Input transactions are
// taken into a two-entry command queue and carried out one at a time by the
// record engine, which owns a single-port-write, registered-read record store.
// A query reads and evaluates each record it examines in turn (store read,
// then add-and-compare), and reports an empty result without reading the
// store on an empty queue; the result waits in an output register so the
// next transaction can start while it is held. Configuration is always
// accepted (cfg_ready is high).
module timestamp_matched_pose_queue (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // req_type
  input  wire logic [tmpq_pkg::REQ_W-1:0]         in_tuser,
  // item_time, pose_handle, pose_status
  input  wire logic [tmpq_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // result_code
  output logic [tmpq_pkg::CODE_W-1:0]             out_tuser,
  // matched_handle, matched_time
  output logic [tmpq_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tmpq_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [tmpq_pkg::CFG_W-1:0]         cfg_data
);

  logic           cmd_valid;
  logic           cmd_ready;
  tmpq_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  tmpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tmpq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
